### hdl/kar_pkg.sv
// Shared types and constants for the key auto-repeat block.
package kar_pkg;

    // Fixed widths of the key fields, the hold timers, the timing registers and the register port.
    localparam int FIELD_W = 10;
    localparam int CNT_W   = 9;
    localparam int CFG_W   = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Register reset values and default key count.
    localparam logic [CFG_W-1:0] DELAY_RESET    = 8'h2D;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 8'h08;
    localparam int               KEY_COUNT_DEF  = 10;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_INITIAL_DELAY   = 1'b0,
        REG_REPEAT_INTERVAL = 1'b1
    } reg_idx_t;

    // Timing settings handed to every lane.
    typedef struct packed {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
        logic [CNT_W-1:0] second;
    } cfg_t;

    // One result item.
    typedef struct packed {
        logic [FIELD_W-1:0] new_presses;
        logic [FIELD_W-1:0] repeat_pulses;
        logic [FIELD_W-1:0] held_now;
    } result_t;

endpackage

### hdl/kar_lane.sv
// Hold timer and repeat pulse logic for one key.
module kar_lane (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic         sample,
    input  logic         pressed,
    input  logic         held_old,
    input  kar_pkg::cfg_t cfg,
    output logic         pulse
);
    import kar_pkg::*;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] inc;
    logic             held_new;

    // Clear on release, count up while held, fold back at the second pulse.
    always_comb begin
        base = (sample && held_old && !pressed) ? '0 : count_reg;
        held_new = sample ? pressed : held_old;
        inc = (base == CNT_MAX) ? base : base + 1'b1;
        pulse = 1'b0;
        count_next = base;
        if (held_new) begin
            count_next = inc;
            if (inc == {1'b0, cfg.delay}) begin
                pulse = 1'b1;
            end else if (inc == cfg.second) begin
                pulse = 1'b1;
                count_next = inc - {1'b0, cfg.interval};
            end
        end
    end

    // Timer register advances once per accepted request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (step_en) begin
            count_reg <= count_next;
        end
    end

endmodule

### hdl/kar_out_buf.sv
// Two-entry output buffer that holds result items toward the result channel.
module kar_out_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  kar_pkg::result_t push_data,
    output logic             can_push,
    output logic             m_valid,
    input  logic             m_ready,
    output kar_pkg::result_t m_data
);
    import kar_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop      = out_valid_reg && m_ready;
    assign can_push = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // While the skid entry is full, no new result is taken; on a pop it moves to the output entry.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload follows the same routing without reset.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end
    end

endmodule

### hdl/key_auto_repeat.sv
// Key auto-repeat: held set, configuration registers, per-key lanes and output buffer.
// Each accepted result is registered in the output buffer: its output entry, or its skid entry while that one waits.
// Throughput: one request per cycle while s_ready is high; all key timers update in parallel lanes.
// A two-entry output buffer keeps s_ready high while one result waits.
// Reset clears the held set and every hold timer at once and loads the
// registers with an initial delay of 45 and a repeat interval of 8.
module key_auto_repeat #(
    parameter int KEY_COUNT = kar_pkg::KEY_COUNT_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_sample_now,
    input  logic [kar_pkg::FIELD_W-1:0] s_key_levels,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [kar_pkg::FIELD_W-1:0] m_new_presses,
    output logic [kar_pkg::FIELD_W-1:0] m_repeat_pulses,
    output logic [kar_pkg::FIELD_W-1:0] m_held_now,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kar_pkg::ADDR_W-1:0]  paddr,
    input  logic [kar_pkg::DATA_W-1:0]  pwdata,
    output logic [kar_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import kar_pkg::*;

    localparam int LANES = (KEY_COUNT < FIELD_W) ? KEY_COUNT : FIELD_W;

    logic [CFG_W-1:0]   delay_reg;
    logic [CFG_W-1:0]   interval_reg;
    logic [FIELD_W-1:0] held_set_reg;
    logic [FIELD_W-1:0] held_set_next;
    logic [FIELD_W-1:0] key_mask;
    logic [FIELD_W-1:0] pressed;
    logic [FIELD_W-1:0] fresh;
    logic [FIELD_W-1:0] pulses;
    logic               accept;
    logic               can_push;
    reg_idx_t           reg_idx;
    cfg_t               cfg;
    result_t            result;
    result_t            m_data;

    // Configuration port: always ready, written on the access phase.
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_reg    <= DELAY_RESET;
            interval_reg <= INTERVAL_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (reg_idx)
                REG_INITIAL_DELAY:   delay_reg    <= pwdata[CFG_W-1:0];
                REG_REPEAT_INTERVAL: interval_reg <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_INITIAL_DELAY:   prdata = {{(DATA_W-CFG_W){1'b0}}, delay_reg};
            REG_REPEAT_INTERVAL: prdata = {{(DATA_W-CFG_W){1'b0}}, interval_reg};
            default:             prdata = '0;
        endcase
    end

    // Timing settings shared by all lanes.
    assign cfg.delay    = delay_reg;
    assign cfg.interval = interval_reg;
    assign cfg.second   = {1'b0, delay_reg} + {1'b0, interval_reg};

    // Only keys below the key count take part.
    for (genvar i = 0; i < FIELD_W; i++) begin : g_mask
        assign key_mask[i] = (i < KEY_COUNT);
    end

    assign s_ready = can_push;
    assign accept  = s_valid && can_push;
    assign pressed = ~s_key_levels & key_mask;

    // New presses and the next held set.
    always_comb begin
        fresh         = '0;
        held_set_next = held_set_reg;
        if (s_sample_now) begin
            fresh         = pressed & ~held_set_reg;
            held_set_next = pressed;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_set_reg <= '0;
        end else if (accept) begin
            held_set_reg <= held_set_next;
        end
    end

    // One timer lane per key below the key count; the other pulse bits are tied low.
    for (genvar i = 0; i < FIELD_W; i++) begin : g_lane
        if (i < LANES) begin : g_on
            kar_lane u_lane (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .step_en  (accept),
                .sample   (s_sample_now),
                .pressed  (pressed[i]),
                .held_old (held_set_reg[i]),
                .cfg      (cfg),
                .pulse    (pulses[i])
            );
        end else begin : g_off
            assign pulses[i] = 1'b0;
        end
    end

    // Merge lane results into one result item.
    assign result.new_presses   = fresh;
    assign result.repeat_pulses = pulses;
    assign result.held_now      = held_set_next;

    kar_out_buf u_out_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (accept),
        .push_data (result),
        .can_push  (can_push),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_new_presses   = m_data.new_presses;
    assign m_repeat_pulses = m_data.repeat_pulses;
    assign m_held_now      = m_data.held_now;

endmodule

### verif/tb_top.sv
// Self-checking testbench for the key auto-repeat block: directed table, random phases, APB setup.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import kar_pkg::*;

    localparam int CLK_PERIOD  = 10;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE      = 4;

    // One row of the directed table; typed rows carry their result, the rest use the predictor.
    typedef struct packed {
        logic               sample;
        logic [FIELD_W-1:0] levels;
        logic               typed;
        logic [FIELD_W-1:0] new_p;
        logic [FIELD_W-1:0] pulses;
        logic [FIELD_W-1:0] held;
    } key_row_t;

    // One random phase: register settings, length, key churn and idle rates.
    typedef struct {
        logic [CFG_W-1:0] delay;
        logic [CFG_W-1:0] interval;
        int               items;
        int               flip_pct;
        int               send_pct;
        int               recv_pct;
    } phase_t;

    localparam int DIR_ROWS     = 20;
    localparam int DIR_FAST_ROW = 11;
    localparam int NUM_PHASES   = 6;

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic                 s_sample_now    = 1'b0;
    logic [FIELD_W-1:0]   s_key_levels    = '1;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic [FIELD_W-1:0]   m_new_presses;
    logic [FIELD_W-1:0]   m_repeat_pulses;
    logic [FIELD_W-1:0]   m_held_now;
    logic                 psel            = 1'b0;
    logic                 penable         = 1'b0;
    logic                 pwrite          = 1'b0;
    logic [ADDR_W-1:0]    paddr           = '0;
    logic [DATA_W-1:0]    pwdata          = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    // Predictor state: held set, per-key timers and the timing registers.
    logic [FIELD_W-1:0]   held_keys = '0;
    logic [CNT_W-1:0]     hold_timer [FIELD_W] = '{default: '0};
    logic [CFG_W-1:0]     tick_delay    = DELAY_RESET;
    logic [CFG_W-1:0]     tick_interval = INTERVAL_RESET;

    // Typed expectation that travels with the request currently offered.
    logic                 row_typed  = 1'b0;
    result_t              row_expect = '0;

    result_t              key_reports_due [$];
    int                   mismatches = 0;
    int                   send_idle  = 0;
    int                   recv_idle  = 0;
    logic                 hold_req   = 1'b0;

    key_row_t dir_rows [DIR_ROWS] = '{
        '{1'b1, 10'h3FF, 1'b1, 10'h000, 10'h000, 10'h000},
        '{1'b0, 10'h000, 1'b1, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h000, 1'b1, 10'h3FF, 10'h000, 10'h3FF},
        '{1'b1, 10'h000, 1'b1, 10'h000, 10'h000, 10'h3FF},
        '{1'b0, 10'h3FF, 1'b1, 10'h000, 10'h000, 10'h3FF},
        '{1'b1, 10'h155, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h2AA, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h3FE, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h1FF, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h3FF, 1'b1, 10'h000, 10'h000, 10'h000},
        '{1'b0, 10'h000, 1'b1, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h3FE, 1'b1, 10'h001, 10'h001, 10'h001},
        '{1'b0, 10'h000, 1'b1, 10'h000, 10'h001, 10'h001},
        '{1'b1, 10'h3FE, 1'b1, 10'h000, 10'h001, 10'h001},
        '{1'b1, 10'h1FC, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b0, 10'h155, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h3FF, 1'b1, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h000, 1'b1, 10'h3FF, 10'h3FF, 10'h3FF},
        '{1'b0, 10'h3FF, 1'b0, 10'h000, 10'h000, 10'h000},
        '{1'b1, 10'h3FF, 1'b1, 10'h000, 10'h000, 10'h000}
    };

    phase_t phases [NUM_PHASES] = '{
        '{8'd2,   8'd3,   25,  10, 30, 55},
        '{8'd1,   8'd255, 10,  8,  30, 55},
        '{8'd7,   8'd1,   40,  6,  55, 30},
        '{8'd0,   8'd4,   10,  6,  55, 30},
        '{8'd255, 8'd0,   520, 0,  0,  0},
        '{8'd45,  8'd8,   10,  3,  0,  0}
    };

    key_auto_repeat u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sample_now    (s_sample_now),
        .s_key_levels    (s_key_levels),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_new_presses   (m_new_presses),
        .m_repeat_pulses (m_repeat_pulses),
        .m_held_now      (m_held_now),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Advance the held set and the hold timers by one tick and return the report.
    function automatic result_t predict_key_tick(input logic sample,
                                                 input logic [FIELD_W-1:0] levels);
        result_t            rep;
        logic [FIELD_W-1:0] pressed;
        logic [CNT_W-1:0]   t;
        logic [CNT_W-1:0]   second_hit;
        rep = '0;
        second_hit = CNT_W'(tick_delay) + CNT_W'(tick_interval);
        if (sample) begin
            pressed = ~levels;
            for (int k = 0; k < FIELD_W; k++) begin
                if (held_keys[k] && !pressed[k]) begin
                    hold_timer[k] = '0;
                end
            end
            rep.new_presses = pressed & ~held_keys;
            held_keys = pressed;
        end
        for (int k = 0; k < FIELD_W; k++) begin
            if (held_keys[k]) begin
                t = hold_timer[k];
                if (t != CNT_MAX) begin
                    t = t + 1'b1;
                end
                if (t == CNT_W'(tick_delay)) begin
                    rep.repeat_pulses[k] = 1'b1;
                end else if (t == second_hit) begin
                    rep.repeat_pulses[k] = 1'b1;
                    t = t - CNT_W'(tick_interval);
                end
                hold_timer[k] = t;
            end
        end
        rep.held_now = held_keys;
        return rep;
    endfunction

    task automatic check_field(input string fname, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %03h, actual %03h", $time, fname, want, got);
            mismatches++;
        end
    endtask

    // Accepted requests are predicted and accepted reports checked in one place per edge.
    always @(posedge aclk) begin : scoreboard
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                want = predict_key_tick(s_sample_now, s_key_levels);
                if (row_typed) begin
                    want = row_expect;
                end
                key_reports_due.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (key_reports_due.size() == 0) begin
                    $display("%0t: unexpected report, expected none, actual %03h %03h %03h",
                             $time, m_new_presses, m_repeat_pulses, m_held_now);
                    mismatches++;
                end else begin
                    want = key_reports_due.pop_front();
                    check_field("new_presses", want.new_presses, m_new_presses);
                    check_field("repeat_pulses", want.repeat_pulses, m_repeat_pulses);
                    check_field("held_now", want.held_now, m_held_now);
                end
            end
        end
    end

    // Result side: random stalls, or one long hold-off when the sequence asks for it.
    initial begin : ready_gen
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    // Offer one request and return at the edge where it is accepted.
    task automatic send_key_tick(input logic sample, input logic [FIELD_W-1:0] levels,
                                 input logic typed, input result_t want);
        s_valid      <= 1'b1;
        s_sample_now <= sample;
        s_key_levels <= levels;
        row_typed    <= typed;
        row_expect   <= want;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Random gap on the request side; idle fraction follows send_idle.
    task automatic sender_pause();
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
    endtask

    // Stop offering and wait until every expected report has come back.
    task automatic wait_reports_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (key_reports_due.size() != 0) @(posedge aclk);
    endtask

    // APB write followed by a read-back of the same register.
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== DATA_W'(value)) begin
            $display("%0t: register %s read-back, expected %08h, actual %08h",
                     $time, idx.name(), DATA_W'(value), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (idx == REG_INITIAL_DELAY) begin
            tick_delay = value;
        end else begin
            tick_interval = value;
        end
    endtask

    // Timing registers change only with the block drained and settled.
    task automatic set_timing(input logic [CFG_W-1:0] delay, input logic [CFG_W-1:0] interval);
        wait_reports_drained();
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_INITIAL_DELAY, delay);
        write_reg(REG_REPEAT_INTERVAL, interval);
    endtask

    // Main sequence: reset, directed table, then random phases.
    initial begin : main_seq
        logic               smp;
        logic [FIELD_W-1:0] lv;
        logic [FIELD_W-1:0] stim_pressed;
        int                 k;
        smp = 1'b0;
        stim_pressed = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle = 30;
        recv_idle = 55;
        for (int r = 0; r < DIR_ROWS; r++) begin
            if (r == DIR_FAST_ROW) begin
                set_timing(8'd1, 8'd1);
            end
            send_key_tick(dir_rows[r].sample, dir_rows[r].levels, dir_rows[r].typed,
                          '{new_presses: dir_rows[r].new_p,
                            repeat_pulses: dir_rows[r].pulses,
                            held_now: dir_rows[r].held});
            sender_pause();
        end

        // Mostly steady key patterns sampled every other tick, with churn and glitches.
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle = phases[p].send_pct;
            recv_idle = phases[p].recv_pct;
            set_timing(phases[p].delay, phases[p].interval);
            if (phases[p].flip_pct == 0) begin
                stim_pressed = FIELD_W'($urandom_range(1, 1023));
            end
            for (int i = 0; i < phases[p].items; i++) begin
                if (p == 0 && i == 20) begin
                    hold_req = 1'b1;
                end
                if (p == 2 && i == 35) begin
                    wait_reports_drained();
                end
                smp = ($urandom_range(7) == 0) ? smp : ~smp;
                if (smp) begin
                    if ($urandom_range(99) < phases[p].flip_pct) begin
                        k = $urandom_range(FIELD_W - 1);
                        stim_pressed[k] = ~stim_pressed[k];
                    end
                    if (phases[p].flip_pct != 0 && $urandom_range(99) < 2) begin
                        lv = FIELD_W'($urandom);
                    end else begin
                        lv = ~stim_pressed;
                    end
                end else begin
                    lv = FIELD_W'($urandom);
                end
                send_key_tick(smp, lv, 1'b0, '0);
                sender_pause();
            end
        end

        wait_reports_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### files.f
hdl/kar_pkg.sv
hdl/kar_lane.sv
hdl/kar_out_buf.sv
hdl/key_auto_repeat.sv
verif/tb_top.sv
